// ===== rtl/core/gpio_ic_pkg.sv =====
// ----------------------------------------------------------------------------
// gpio_ic_pkg: shared types and codes of the GPIO interrupt controller
// Word formats of both channels, operation codes and register addresses.
// ----------------------------------------------------------------------------
package gpio_ic_pkg;

	localparam int PIN_W = 32;

	// operation codes
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// register addresses
	localparam logic [2:0] ADDR_OUT    = 3'd0;
	localparam logic [2:0] ADDR_OE     = 3'd1;
	localparam logic [2:0] ADDR_IN     = 3'd2;
	localparam logic [2:0] ADDR_EDGE   = 3'd3;
	localparam logic [2:0] ADDR_POL    = 3'd4;
	localparam logic [2:0] ADDR_ENABLE = 3'd5;
	localparam logic [2:0] ADDR_STATUS = 3'd6;
	localparam logic [2:0] ADDR_CLEAR  = 3'd7;

	typedef struct packed {
		logic [1:0]       op;
		logic [2:0]       reg_addr;
		logic [PIN_W-1:0] write_data;
		logic [PIN_W-1:0] pins_in;
	} in_word_t;

	typedef struct packed {
		logic [PIN_W-1:0] read_data;
		logic             irq_line;
		logic [PIN_W-1:0] pin_drive;
		logic [PIN_W-1:0] pin_enable;
	} out_word_t;

endpackage

// ===== rtl/core/gpio_ic_core.sv =====
// ----------------------------------------------------------------------------
// gpio_ic_core: register file and interrupt status logic
// Holds the pin and interrupt registers, applies one word per advance and
// presents the result word that follows from the updated state.
// ----------------------------------------------------------------------------
module gpio_ic_core #(
	parameter int PIN_COUNT = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  latch_level,
	input  gpio_ic_pkg::in_word_t item,
	output gpio_ic_pkg::out_word_t res
);

	logic [PIN_COUNT-1:0] out_q, oe_q, edge_q, pol_q, en_q, status_q, last_q;
	logic [PIN_COUNT-1:0] out_nx, oe_nx, edge_nx, pol_nx, en_nx, status_nx, last_nx;
	logic [PIN_COUNT-1:0] pins, data, rise, fall, edge_hit, level_act, rd;

	assign pins      = item.pins_in[PIN_COUNT-1:0];
	assign data      = item.write_data[PIN_COUNT-1:0];
	assign rise      = pins & ~last_q;
	assign fall      = ~pins & last_q;
	assign edge_hit  = edge_q & ((pol_q & rise) | (~pol_q & fall));
	assign level_act = ~edge_q & ~(pins ^ pol_q);

	always_comb begin
		out_nx    = out_q;
		oe_nx     = oe_q;
		edge_nx   = edge_q;
		pol_nx    = pol_q;
		en_nx     = en_q;
		status_nx = status_q;
		last_nx   = last_q;
		rd        = '0;
		case (item.op)
			gpio_ic_pkg::OP_SAMPLE: begin
				// level lines either stick or follow the pin, edge lines always stick
				if (latch_level)
					status_nx = status_q | edge_hit | level_act;
				else
					status_nx = (status_q & edge_q) | edge_hit | level_act;
				last_nx = pins;
			end
			gpio_ic_pkg::OP_WRITE: begin
				case (item.reg_addr)
					gpio_ic_pkg::ADDR_OUT:    out_nx = data;
					gpio_ic_pkg::ADDR_OE:     oe_nx = data;
					gpio_ic_pkg::ADDR_EDGE:   edge_nx = data;
					gpio_ic_pkg::ADDR_POL:    pol_nx = data;
					gpio_ic_pkg::ADDR_ENABLE: en_nx = data;
					gpio_ic_pkg::ADDR_CLEAR:  status_nx = status_q & ~data;
					default: ;
				endcase
			end
			gpio_ic_pkg::OP_READ: begin
				case (item.reg_addr)
					gpio_ic_pkg::ADDR_OUT:    rd = out_q;
					gpio_ic_pkg::ADDR_OE:     rd = oe_q;
					gpio_ic_pkg::ADDR_IN:     rd = last_q;
					gpio_ic_pkg::ADDR_EDGE:   rd = edge_q;
					gpio_ic_pkg::ADDR_POL:    rd = pol_q;
					gpio_ic_pkg::ADDR_ENABLE: rd = en_q;
					gpio_ic_pkg::ADDR_STATUS: rd = status_q;
					default:                  rd = '0;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		res.read_data  = gpio_ic_pkg::PIN_W'(rd);
		res.irq_line   = |(status_nx & en_nx);
		res.pin_drive  = gpio_ic_pkg::PIN_W'(out_nx);
		res.pin_enable = gpio_ic_pkg::PIN_W'(oe_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q    <= '0;
			oe_q     <= '0;
			edge_q   <= '0;
			pol_q    <= '0;
			en_q     <= '0;
			status_q <= '0;
			last_q   <= '0;
		end else if (advance) begin
			out_q    <= out_nx;
			oe_q     <= oe_nx;
			edge_q   <= edge_nx;
			pol_q    <= pol_nx;
			en_q     <= en_nx;
			status_q <= status_nx;
			last_q   <= last_nx;
		end
	end

endmodule

// ===== rtl/core/gpio_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// gpio_interrupt_controller: GPIO block with edge and level interrupts
// Pin output, output enable and interrupt registers behind a word channel.
// ----------------------------------------------------------------------------
// Each input word is a pin sample, a register write or a register read; each
// one yields exactly one output word carrying the read value, the summary
// interrupt and the pin drive and enable after the word took effect. The
// block takes one word per clock and delivers one per clock while the output
// is not stalled; a word passes through the input register, then the result
// register that follows the register-file update. Pins at or above PIN_COUNT
// are dropped on writes and samples and read as zero.
// latch_level (reset 1) selects sticky level status; write it only while
// the block is empty.
module gpio_interrupt_controller #(
	parameter int PIN_COUNT = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  gpio_ic_pkg::in_word_t  in_word,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output gpio_ic_pkg::out_word_t out_word,
	// configuration
	input  logic                   cfg_wr_en,
	input  logic                   cfg_wr_data
);

	logic                   valid_s1;
	gpio_ic_pkg::in_word_t  item_s1;
	logic                   out_valid_q;
	gpio_ic_pkg::out_word_t out_word_q;
	gpio_ic_pkg::out_word_t res;
	logic                   latch_level_q;
	logic                   advance;
	logic                   load_s1;

	// advance the held word when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	// hold the input only when a word is stuck in stage one
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	gpio_ic_core #(
		.PIN_COUNT(PIN_COUNT)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.latch_level(latch_level_q),
		.item       (item_s1),
		.res        (res)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			latch_level_q <= 1'b1;
		end else begin
			if (load_s1)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_wr_en)
				latch_level_q <= cfg_wr_data;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (load_s1)
			item_s1 <= in_word;
		if (advance)
			out_word_q <= res;
	end

endmodule

// ===== rtl/core/gpio_ic_checker.sv =====
// ----------------------------------------------------------------------------
// gpio_ic_checker: port-level checks of the GPIO interrupt controller
// Watches both channels and the result words; bound to the top level.
// ----------------------------------------------------------------------------
module gpio_ic_checker #(
	parameter int PIN_COUNT = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input gpio_ic_pkg::out_word_t out_word
);

	logic [gpio_ic_pkg::PIN_W-1:0] unused_mask;
	assign unused_mask = ~gpio_ic_pkg::PIN_W'((64'd1 << PIN_COUNT) - 64'd1);

	// a stalled output word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// input is held back only when the output side is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

	// unused pins never show up in a delivered word
	a_unused_pins: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_word.read_data | out_word.pin_drive |
			out_word.pin_enable) & unused_mask) == '0)
		else $error("unused pin bit set in output word");

	// with nothing coming in and no output stall, the input register and then the result register drain empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid && !out_stall ##1 !in_valid && !out_stall |=> !out_valid)
		else $error("output word appeared without an input word");

endmodule

bind gpio_interrupt_controller gpio_ic_checker #(
	.PIN_COUNT(PIN_COUNT)
) u_gpio_ic_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_word (out_word)
);

// ===== bench/gpio_interrupt_controller_test.sv =====
// ----------------------------------------------------------------------------
// gpio_interrupt_controller_test: self-checking bench of the GPIO block
// Feeds pin samples, register writes and reads through the word channel.
// Both channels idle at random. Every reply is compared, field by field,
// with a cycle-free prediction of the register file and interrupt status.
// The sticky level setting changes between drained phases.
// ----------------------------------------------------------------------------
module gpio_interrupt_controller_test;

	import gpio_ic_pkg::*;

	localparam int PIN_COUNT = 32;
	localparam logic [PIN_W-1:0] PIN_MASK = {PIN_W{1'b1}} >> (PIN_W - PIN_COUNT);
	// the op field has one spare code that the block must ignore
	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam int MAX_SHOWN = 10;
	localparam int RUN_LIMIT = 3_000_000;

	typedef enum int { RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY } rx_mode_e;

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      in_valid    = 1'b0;
	logic      in_stall;
	in_word_t  in_word     = '0;
	logic      out_valid;
	logic      out_stall   = 1'b0;
	out_word_t out_word;
	logic      cfg_wr_en   = 1'b0;
	logic      cfg_wr_data = 1'b0;

	// words waiting to be sent, and replies owed by the block, oldest first
	in_word_t  cmds_waiting[$];
	out_word_t replies_due[$];

	// predicted register file and interrupt status
	logic             st_latch;
	logic [PIN_W-1:0] st_out, st_oe, st_edge_sel, st_pol, st_enable, st_status, st_last_pins;

	// stimulus side
	logic [PIN_W-1:0] gen_pins = '0;
	int               burst_left = 0;
	int               gap_left = 0;
	logic             in_taken = 1'b0;
	rx_mode_e         rx_mode = RX_FREE;
	int unsigned      rx_tick = 0;
	int               mismatches = 0;

	gpio_interrupt_controller #(
		.PIN_COUNT(PIN_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #6 clk = ~clk;

	// Apply one word to the predicted state and return the reply it owes.
	function automatic out_word_t predict_reply(in_word_t w);
		logic [PIN_W-1:0] data, pins, rise, fall, edge_hit, level_act;
		out_word_t r;
		data = w.write_data & PIN_MASK;
		pins = w.pins_in & PIN_MASK;
		r = '0;
		case (w.op)
			OP_SAMPLE: begin
				rise = pins & ~st_last_pins;
				fall = ~pins & st_last_pins;
				edge_hit = st_edge_sel & ((st_pol & rise) | (~st_pol & fall));
				level_act = ~st_edge_sel & ~(pins ^ st_pol);
				// non-sticky level lines follow the pin; edge lines stay latched
				if (st_latch) begin
					st_status = st_status | edge_hit | level_act;
				end else begin
					st_status = (st_status & st_edge_sel) | edge_hit | level_act;
				end
				st_status = st_status & PIN_MASK;
				st_last_pins = pins;
			end
			OP_WRITE: begin
				// in and status are read only, so writes to them fall through
				case (w.reg_addr)
					ADDR_OUT:    st_out = data;
					ADDR_OE:     st_oe = data;
					ADDR_EDGE:   st_edge_sel = data;
					ADDR_POL:    st_pol = data;
					ADDR_ENABLE: st_enable = data;
					ADDR_CLEAR:  st_status = st_status & ~data;
					default:     ;
				endcase
			end
			OP_READ: begin
				case (w.reg_addr)
					ADDR_OUT:    r.read_data = st_out;
					ADDR_OE:     r.read_data = st_oe;
					ADDR_IN:     r.read_data = st_last_pins;
					ADDR_EDGE:   r.read_data = st_edge_sel;
					ADDR_POL:    r.read_data = st_pol;
					ADDR_ENABLE: r.read_data = st_enable;
					ADDR_STATUS: r.read_data = st_status;
					default:     r.read_data = '0;
				endcase
			end
			default: ;
		endcase
		r.irq_line = |(st_status & st_enable);
		r.pin_drive = st_out;
		r.pin_enable = st_oe;
		return r;
	endfunction

	function automatic in_word_t make_cmd(logic [1:0] op, logic [2:0] addr,
			logic [PIN_W-1:0] data, logic [PIN_W-1:0] pins);
		in_word_t w;
		w.op = op;
		w.reg_addr = addr;
		w.write_data = data;
		w.pins_in = pins;
		return w;
	endfunction

	// Pin patterns: half the time small changes from the last one so edges stay
	// sparse, with whole-bus swings and fresh random values mixed in.
	function automatic logic [PIN_W-1:0] next_pins();
		case ($urandom_range(0, 7))
			0:       gen_pins = '0;
			1:       gen_pins = '1;
			2, 3:    gen_pins = $urandom();
			4:       gen_pins = gen_pins ^ ($urandom() & $urandom() & $urandom());
			default: gen_pins = gen_pins ^ (32'd1 << $urandom_range(0, PIN_W - 1));
		endcase
		return gen_pins;
	endfunction

	function automatic in_word_t random_cmd();
		in_word_t w;
		int unsigned pick;
		w.reg_addr = 3'($urandom_range(0, 7));
		w.write_data = $urandom();
		w.pins_in = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 42) begin
			w.op = OP_SAMPLE;
			w.pins_in = next_pins();
		end else if (pick < 75) begin
			w.op = OP_WRITE;
			case ($urandom_range(0, 5))
				0:       w.write_data = '1;
				1:       w.write_data = '0;
				default: ;
			endcase
		end else if (pick < 96) begin
			w.op = OP_READ;
		end else begin
			w.op = OP_IGNORED;
		end
		return w;
	endfunction

	task automatic reset_prediction();
		st_latch = 1'b1;
		st_out = '0;
		st_oe = '0;
		st_edge_sel = '0;
		st_pol = '0;
		st_enable = '0;
		st_status = '0;
		st_last_pins = '0;
	endtask

	// Hold until every queued word has gone in and every reply has come out.
	task automatic drain();
		while (cmds_waiting.size() != 0 || in_valid || replies_due.size() != 0)
			@(negedge clk);
	endtask

	// Write the sticky level setting; the block is empty here.
	task automatic set_latch_level(logic value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		st_latch = value;
	endtask

	task automatic random_phase(logic latch, int count);
		drain();
		set_latch_level(latch);
		repeat (count) cmds_waiting.push_back(random_cmd());
	endtask

	task automatic note_mismatch(string what, logic [PIN_W-1:0] want, logic [PIN_W-1:0] got);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
	endtask

	// Sender: advance to the next word only once the current one is taken.
	// Words go out in bursts of random length with random gaps between them;
	// a zero gap now and then gives long stretches at full rate.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (cmds_waiting.size() != 0) begin
				in_word <= cmds_waiting.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall on a pattern of its own that switches mode now and then.
	always @(negedge clk) begin
		rx_tick++;
		if (rx_tick % 97 == 0)
			rx_mode = rx_mode_e'($urandom_range(0, 3));
		case (rx_mode)
			RX_FREE:     out_stall <= 1'b0;
			RX_LIGHT:    out_stall <= ($urandom_range(0, 2) == 0);
			RX_PERIODIC: out_stall <= (rx_tick % 5) < 2;
			default:     out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// Monitor: predict on every accepted input word, check every accepted
	// output word against the oldest reply due.
	always @(posedge clk) begin : monitor
		out_word_t due;
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall)
				replies_due.push_back(predict_reply(in_word));
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					note_mismatch("reply with none due, read_data", '0, out_word.read_data);
				end else begin
					due = replies_due.pop_front();
					if (out_word.read_data !== due.read_data)
						note_mismatch("read_data", due.read_data, out_word.read_data);
					if (out_word.irq_line !== due.irq_line)
						note_mismatch("irq_line", due.irq_line, out_word.irq_line);
					if (out_word.pin_drive !== due.pin_drive)
						note_mismatch("pin_drive", due.pin_drive, out_word.pin_drive);
					if (out_word.pin_enable !== due.pin_enable)
						note_mismatch("pin_enable", due.pin_enable, out_word.pin_enable);
				end
			end
		end
	end

	initial begin
		reset_prediction();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words, sticky level status from reset.
		// Enable every line, then a low sample sets all active-low level lines.
		cmds_waiting.push_back(make_cmd(OP_WRITE, ADDR_ENABLE, '1, '0));
		cmds_waiting.push_back(make_cmd(OP_SAMPLE, ADDR_OUT, '0, '0));
		cmds_waiting.push_back(make_cmd(OP_READ, ADDR_STATUS, '0, '1));
		// Clear everything; the level lines come back only on a new sample.
		cmds_waiting.push_back(make_cmd(OP_WRITE, ADDR_CLEAR, '1, '0));
		cmds_waiting.push_back(make_cmd(OP_READ, ADDR_STATUS, '0, '0));
		cmds_waiting.push_back(make_cmd(OP_SAMPLE, ADDR_OUT, '0, '1));
		cmds_waiting.push_back(make_cmd(OP_READ, ADDR_IN, '1, '0));
		// Odd lines edge, active high: no hit on the falling sample, hits on the rise.
		cmds_waiting.push_back(make_cmd(OP_WRITE, ADDR_POL, '1, '0));
		cmds_waiting.push_back(make_cmd(OP_WRITE, ADDR_EDGE, 32'haaaa_aaaa, '0));
		cmds_waiting.push_back(make_cmd(OP_SAMPLE, ADDR_OUT, '0, '0));
		cmds_waiting.push_back(make_cmd(OP_SAMPLE, ADDR_OUT, '0, '1));
		cmds_waiting.push_back(make_cmd(OP_READ, ADDR_STATUS, '0, '0));
		// Falling edges with active-low polarity, then clear lines still active.
		cmds_waiting.push_back(make_cmd(OP_WRITE, ADDR_POL, '0, '1));
		cmds_waiting.push_back(make_cmd(OP_SAMPLE, ADDR_OUT, '0, '0));
		cmds_waiting.push_back(make_cmd(OP_WRITE, ADDR_CLEAR, 32'h5555_5555, '0));
		cmds_waiting.push_back(make_cmd(OP_SAMPLE, ADDR_OUT, '0, '0));
		cmds_waiting.push_back(make_cmd(OP_READ, ADDR_STATUS, '0, '0));
		// Read-only registers ignore writes; clear reads as zero; spare op does nothing.
		cmds_waiting.push_back(make_cmd(OP_WRITE, ADDR_IN, '1, '1));
		cmds_waiting.push_back(make_cmd(OP_WRITE, ADDR_STATUS, '0, '1));
		cmds_waiting.push_back(make_cmd(OP_READ, ADDR_CLEAR, '1, '1));
		cmds_waiting.push_back(make_cmd(OP_IGNORED, ADDR_OUT, '1, '1));
		// Drive every pin, read the drive and output enable back, then drop the interrupt enables.
		cmds_waiting.push_back(make_cmd(OP_WRITE, ADDR_OUT, '1, '0));
		cmds_waiting.push_back(make_cmd(OP_WRITE, ADDR_OE, '1, '0));
		cmds_waiting.push_back(make_cmd(OP_READ, ADDR_OUT, '0, '0));
		cmds_waiting.push_back(make_cmd(OP_READ, ADDR_OE, '0, '0));
		cmds_waiting.push_back(make_cmd(OP_WRITE, ADDR_ENABLE, '0, '0));

		// Random phases, alternating level behavior; each starts from an
		// empty block, so the sender pauses until every reply has come.
		random_phase(1'b0, 300);
		random_phase(1'b1, 300);
		random_phase(1'b0, 200);
		random_phase(1'b1, 150);

		drain();
		repeat (4) @(negedge clk);
		if (mismatches == 0 && replies_due.size() == 0) begin
			$display("gpio_interrupt_controller_test OK");
		end else begin
			$display("gpio_interrupt_controller_test NOT OK");
		end
		$finish;
	end

	// Drop out if the block hangs.
	initial begin
		#(RUN_LIMIT);
		$display("gpio_interrupt_controller_test NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/gpio_ic_pkg.sv
rtl/core/gpio_ic_core.sv
rtl/core/gpio_interrupt_controller.sv
rtl/core/gpio_ic_checker.sv
bench/gpio_interrupt_controller_test.sv
